// ===== src/spm_rng_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// spm_rng_pkg
// Shared types, constants and the Lehmer fold for the shuffled generator.
// ----------------------------------------------------------------------------
package spm_rng_pkg;

  localparam int unsigned STATE_W = 31;
  localparam int unsigned MULT_W  = 15;
  localparam int unsigned PROD_W  = STATE_W + MULT_W;

  localparam logic [MULT_W-1:0]  LEH_MULT = 15'd16807;
  localparam logic [STATE_W-1:0] LEH_MOD  = 31'h7FFF_FFFF;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEED_MUL,
    ST_SEED_RED,
    ST_DRAW_MUL,
    ST_DRAW_RED,
    ST_DRAW_QD,
    ST_DRAW_SLOT,
    ST_DRAW_READ,
    ST_DRAW_DONE
  } rng_state_t;

  typedef struct packed {
    logic load_seed;
    logic step_mul;
    logic step_red;
    logic fill_step;
    logic slot_mul;
    logic slot_q;
    logic slot_qd;
    logic slot_fix;
    logic tbl_read;
    logic finish;
  } rng_cmd_t;

  typedef struct packed {
    logic fill_done;
    logic seeded;
  } rng_status_t;

  // Folds state * 16807 back below 2^31 - 1. The product of a nonzero state
  // folds to less than twice the modulus, so one subtraction suffices.
  function automatic logic [STATE_W-1:0] lehmer_fold(input logic [PROD_W-1:0] prod);
    logic [STATE_W:0] sum;
    sum = {1'b0, prod[STATE_W-1:0]} + {{(STATE_W + 1 - MULT_W){1'b0}}, prod[PROD_W-1:STATE_W]};
    if (sum >= {1'b0, LEH_MOD}) begin
      sum = sum - {1'b0, LEH_MOD};
    end
    return sum[STATE_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== src/spm_rng_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// spm_rng_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module spm_rng_ram #(
  parameter int unsigned WIDTH = 31,
  parameter int unsigned DEPTH = 32
) (
  input  wire                       clk,
  input  wire                       wr_en,
  input  wire [$clog2(DEPTH)-1:0]   wr_addr,
  input  wire [WIDTH-1:0]           wr_data,
  input  wire                       rd_en,
  input  wire [$clog2(DEPTH)-1:0]   rd_addr,
  output logic [WIDTH-1:0]          rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== src/spm_rng_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// spm_rng_ctrl
// Sequencer for reseed, table fill and shuffled draw; owns the output valid.
// ----------------------------------------------------------------------------
module spm_rng_ctrl (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       in_valid,
  input  wire                       in_reseed,
  output logic                      in_ready,
  output logic                      out_valid,
  input  wire                       out_ready,
  input  spm_rng_pkg::rng_status_t  status,
  output spm_rng_pkg::rng_cmd_t     cmd
);
  import spm_rng_pkg::*;

  rng_state_t state;
  rng_state_t state_next;
  logic       accept;
  logic       out_free;

  assign accept   = in_valid && (state == ST_IDLE);
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (in_reseed || !status.seeded) ? ST_SEED_MUL : ST_DRAW_MUL;
        end
      end
      ST_SEED_MUL:  state_next = ST_SEED_RED;
      ST_SEED_RED:  state_next = status.fill_done ? ST_DRAW_MUL : ST_SEED_MUL;
      ST_DRAW_MUL:  state_next = ST_DRAW_RED;
      ST_DRAW_RED:  state_next = ST_DRAW_QD;
      ST_DRAW_QD:   state_next = ST_DRAW_SLOT;
      ST_DRAW_SLOT: state_next = ST_DRAW_READ;
      ST_DRAW_READ: state_next = ST_DRAW_DONE;
      ST_DRAW_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default:      state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.load_seed = accept && (in_reseed || !status.seeded);
      end
      ST_SEED_MUL: cmd.step_mul = 1'b1;
      ST_SEED_RED: begin
        cmd.step_red  = 1'b1;
        cmd.fill_step = 1'b1;
      end
      ST_DRAW_MUL: begin
        cmd.step_mul = 1'b1;
        cmd.slot_mul = 1'b1;
      end
      ST_DRAW_RED: begin
        cmd.step_red = 1'b1;
        cmd.slot_q   = 1'b1;
      end
      ST_DRAW_QD:   cmd.slot_qd  = 1'b1;
      ST_DRAW_SLOT: cmd.slot_fix = 1'b1;
      ST_DRAW_READ: cmd.tbl_read = 1'b1;
      ST_DRAW_DONE: cmd.finish   = out_free;
      default: begin
        cmd      = '0;
        in_ready = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== src/spm_rng_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// spm_rng_dp
// Lehmer stepper, shuffle slot divider, fill counter and shuffle table.
// ----------------------------------------------------------------------------
module spm_rng_dp #(
  parameter int unsigned TABLE_DEPTH  = 32,
  parameter int unsigned WARMUP_STEPS = 8
) (
  input  wire                       clk,
  input  wire                       rst,
  input  wire [30:0]                seed,
  input  spm_rng_pkg::rng_cmd_t     cmd,
  output spm_rng_pkg::rng_status_t  status,
  output logic [30:0]               deviate
);
  import spm_rng_pkg::*;

  localparam int unsigned AW   = $clog2(TABLE_DEPTH);
  localparam int unsigned QW   = AW + 1;
  localparam int unsigned LOOP = TABLE_DEPTH + WARMUP_STEPS;
  localparam int unsigned CW   = $clog2(LOOP + 1);

  localparam logic [63:0] MOD64   = 64'd2147483647;
  localparam logic [63:0] DIV64   = 64'd1 + (MOD64 - 64'd1) / TABLE_DEPTH;
  localparam logic [63:0] RECIP64 = (64'd1 << 31) / DIV64;

  localparam logic [STATE_W-1:0] SLOT_DIV   = DIV64[STATE_W-1:0];
  localparam logic [QW-1:0]      SLOT_RECIP = RECIP64[QW-1:0];
  localparam logic [QW-1:0]      SLOT_MAX   = QW'(TABLE_DEPTH - 1);
  localparam logic [CW-1:0]      LOOP_LAST  = CW'(LOOP - 1);
  localparam logic [CW-1:0]      WARM_CNT   = CW'(WARMUP_STEPS);

  logic [STATE_W-1:0]    lehmer;
  logic [STATE_W-1:0]    last;
  logic [PROD_W-1:0]     prod;
  logic [STATE_W+QW-1:0] qprod;
  logic [QW-1:0]         qest;
  logic [STATE_W+QW-1:0] qd;
  logic [AW-1:0]         slot;
  logic [CW-1:0]         count;
  logic                  seeded;

  logic [STATE_W-1:0]    folded;
  logic [STATE_W-1:0]    seed_clean;
  logic [CW-1:0]         fill_idx;
  logic [STATE_W-1:0]    rem;
  logic [QW-1:0]         qfix;
  logic [AW-1:0]         slot_next;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [STATE_W-1:0]    wr_data;
  logic [STATE_W-1:0]    rd_data;

  assign folded     = lehmer_fold(prod);
  assign seed_clean = (seed == '0 || seed == LEH_MOD) ? STATE_W'(1) : seed;
  assign fill_idx   = LOOP_LAST - count;

  assign status.fill_done = (count == LOOP_LAST);
  assign status.seeded    = seeded;

  always_comb begin
    rem  = last - qd[STATE_W-1:0];
    qfix = (rem >= SLOT_DIV) ? qest + QW'(1) : qest;
    if (qfix > SLOT_MAX) begin
      qfix = SLOT_MAX;
    end
    slot_next = qfix[AW-1:0];
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = slot;
    wr_data = lehmer;
    if (cmd.fill_step && count >= WARM_CNT) begin
      wr_en   = 1'b1;
      wr_addr = fill_idx[AW-1:0];
      wr_data = folded;
    end else if (cmd.finish) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      seeded <= 1'b0;
    end else begin
      if (cmd.load_seed) begin
        count <= '0;
      end else if (cmd.fill_step) begin
        if (status.fill_done) begin
          seeded <= 1'b1;
          count  <= '0;
        end else begin
          count <= count + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lehmer <= STATE_W'(1);
      last   <= '0;
    end else begin
      if (cmd.load_seed) begin
        lehmer <= seed_clean;
      end else if (cmd.step_red) begin
        lehmer <= folded;
      end
      if (cmd.fill_step && status.fill_done) begin
        last <= folded;
      end else if (cmd.finish) begin
        last <= rd_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step_mul) begin
      prod <= lehmer * LEH_MULT;
    end
    if (cmd.slot_mul) begin
      qprod <= last * SLOT_RECIP;
    end
    if (cmd.slot_q) begin
      qest <= qprod[STATE_W+QW-1:STATE_W];
    end
    if (cmd.slot_qd) begin
      qd <= qest * SLOT_DIV;
    end
    if (cmd.slot_fix) begin
      slot <= slot_next;
    end
    if (cmd.finish) begin
      deviate <= rd_data;
    end
  end

  spm_rng_ram #(
    .WIDTH (STATE_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (cmd.tbl_read),
    .rd_addr (slot),
    .rd_data (rd_data)
  );

endmodule
`default_nettype wire

// ===== src/shuffled_park_miller_rng.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// shuffled_park_miller_rng
// Minimal-standard Lehmer generator behind a Bays-Durham shuffle table.
// ----------------------------------------------------------------------------
// Channel   Direction  Payload
// s_axis    in         tuser: operation (1 = reseed then draw), tdata: seed
// m_axis    out        tdata: deviate
//
// A draw runs a Lehmer step, the slot divide and the registered table read,
// then loads the result register once the output register is free; the next
// item can be accepted once the controller is back in idle. A reseed first
// runs TABLE_DEPTH + WARMUP_STEPS Lehmer steps for the warm-up and table fill.
// Each Lehmer step is a multiply, then a modulus fold.
// Reset clears the control state, the last output and the seeded flag and sets
// the Lehmer state to one; the table is filled by every reseed.
// One item is in work at a time; a finished result waits in the output
// register while the next item is accepted.
// ----------------------------------------------------------------------------
module shuffled_park_miller_rng #(
  parameter int unsigned TABLE_DEPTH  = 32,
  parameter int unsigned WARMUP_STEPS = 8
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire [31:0]  s_axis_tdata,   // [30:0] seed, [31] zero
  input  wire         s_axis_tuser,   // [0] operation
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [31:0] m_axis_tdata    // [30:0] deviate, [31] zero
);
  import spm_rng_pkg::*;

  rng_cmd_t    cmd;
  rng_status_t status;
  logic [30:0] deviate;

  spm_rng_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_reseed (s_axis_tuser),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .status    (status),
    .cmd       (cmd)
  );

  // A draw before any reseed loads a zero seed, which the datapath turns into one.
  spm_rng_dp #(
    .TABLE_DEPTH  (TABLE_DEPTH),
    .WARMUP_STEPS (WARMUP_STEPS)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .seed    (s_axis_tuser ? s_axis_tdata[30:0] : 31'd0),
    .cmd     (cmd),
    .status  (status),
    .deviate (deviate)
  );

  assign m_axis_tdata = {1'b0, deviate};

endmodule
`default_nettype wire
